### design/bdq_pkg.sv
package bdq_pkg;

   localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [2:0] ACT_POP_BACK   = 3'd3;
   localparam logic [2:0] ACT_REMOVE_ALL = 3'd4;
   localparam logic [2:0] ACT_FIND       = 3'd5;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] popped_value;
      logic [6:0]         removed_count;
      logic               found;
      logic [5:0]         position;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

### design/bdq_ram.sv
module bdq_ram
   import bdq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  mem_ctl_type              mem_ctl,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [31:0]              wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [31:0]              rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/bdq_ctrl.sv
module bdq_ctrl
   import bdq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   output mem_ctl_type              mem_ctl,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output logic [31:0]              wr_data,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic [31:0]              rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] CNT_DEPTH = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   typedef enum logic [1:0] {
      IDLE,
      DISPATCH,
      POP_WAIT,
      SCAN
   } state_type;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + (AW + 1)'(off);
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[AW-1:0];
   endfunction

   state_type   state_ff, state_in;
   logic        busy_ff, busy_in;
   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   req_type     req_ff, req_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] w_ff, w_in;
   logic        pend_ff, pend_in;
   logic [CW-1:0] pend_idx_ff, pend_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic full, empty, issue;

   assign full  = count_ff == CNT_DEPTH;
   assign empty = count_ff == '0;
   assign issue = rd_idx_ff < count_ff;

   always_comb begin
      logic [31:0] wide;
      wide         = '0;
      state_in     = state_ff;
      busy_in      = busy_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      req_in       = req_ff;
      rd_idx_in    = rd_idx_ff;
      w_in         = w_ff;
      pend_in      = 1'b0;
      pend_idx_in  = rd_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      mem_ctl      = '0;
      wr_addr      = slot_of(front_ff, w_ff);
      wr_data      = rd_data;
      rd_addr      = slot_of(front_ff, rd_idx_ff);

      case (state_ff)
         IDLE: begin
            if (start) begin
               req_in   = req_data;
               busy_in  = 1'b1;
               state_in = DISPATCH;
            end
         end
         DISPATCH: begin
            state_in     = IDLE;
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
            case (req_ff.action)
               ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                  if (full) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     mem_ctl.wr_en = 1'b1;
                     wr_data       = req_ff.value;
                     count_in      = count_ff + 1'b1;
                     if (req_ff.action == ACT_PUSH_FRONT) begin
                        front_in = (front_ff == '0) ? LAST_SLOT : front_ff - 1'b1;
                        wr_addr  = front_in;
                     end else begin
                        wr_addr = slot_of(front_ff, count_ff);
                     end
                  end
               end
               ACT_POP_FRONT, ACT_POP_BACK: begin
                  if (empty) begin
                     rsp_in.status = STATUS_EMPTY;
                  end else begin
                     mem_ctl.rd_en = 1'b1;
                     count_in      = count_ff - 1'b1;
                     rsp_valid_in  = 1'b0;
                     busy_in       = 1'b1;
                     state_in      = POP_WAIT;
                     if (req_ff.action == ACT_POP_FRONT) begin
                        rd_addr  = front_ff;
                        front_in = (front_ff == LAST_SLOT) ? '0 : front_ff + 1'b1;
                     end else begin
                        rd_addr = slot_of(front_ff, count_ff - 1'b1);
                     end
                  end
               end
               ACT_REMOVE_ALL, ACT_FIND: begin
                  rsp_valid_in = 1'b0;
                  busy_in      = 1'b1;
                  rd_idx_in    = '0;
                  w_in         = '0;
                  state_in     = SCAN;
               end
               default: begin
               end
            endcase
         end
         POP_WAIT: begin
            rsp_in.popped_value = rd_data;
            rsp_in.status       = STATUS_OK;
            rsp_valid_in        = 1'b1;
            busy_in             = 1'b0;
            state_in            = IDLE;
         end
         SCAN: begin
            if (issue) begin
               mem_ctl.rd_en = 1'b1;
               rd_idx_in     = rd_idx_ff + 1'b1;
               pend_in       = 1'b1;
            end
            if (pend_ff) begin
               if (req_ff.action == ACT_REMOVE_ALL) begin
                  if (rd_data != req_ff.value) begin
                     mem_ctl.wr_en = 1'b1;
                     w_in          = w_ff + 1'b1;
                  end
               end else if (rd_data == req_ff.value) begin
                  wide            = 32'(pend_idx_ff);
                  rsp_in.found    = 1'b1;
                  rsp_in.position = wide[5:0];
                  rsp_in.status   = STATUS_OK;
                  rsp_valid_in    = 1'b1;
                  busy_in         = 1'b0;
                  state_in        = IDLE;
               end
            end else if (!issue) begin
               rsp_valid_in = 1'b1;
               busy_in      = 1'b0;
               state_in     = IDLE;
               if (req_ff.action == ACT_REMOVE_ALL) begin
                  wide                 = 32'(count_ff - w_ff);
                  rsp_in.removed_count = wide[6:0];
                  count_in             = w_ff;
               end else begin
                  rsp_in.status = STATUS_NOT_FOUND;
               end
            end
         end
         default: begin
            state_in = IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         busy_ff      <= 1'b0;
         front_ff     <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      rd_idx_ff   <= rd_idx_in;
      w_ff        <= w_in;
      pend_idx_ff <= pend_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_DEPTH)
      else $error("entry count exceeds depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy_ff |=> busy_ff)
      else $error("accepted transaction did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff && state_ff == IDLE)
      else $error("response strobe while still busy");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en && mem_ctl.rd_en |-> wr_addr != rd_addr)
      else $error("compaction write hits the slot being read");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == DISPATCH && !full &&
      (req_ff.action == ACT_PUSH_FRONT || req_ff.action == ACT_PUSH_BACK)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not grow the deque");

endmodule

### design/bounded_deque_with_search.sv
// Channel   Direction  Handshake                Payload
// request   in         start && !busy           req_data  (action, value)
// response  out        rsp_valid, one cycle     rsp_data  (popped_value, removed_count,
//                                                          found, position, status)
//
// Push answers from DISPATCH, pop from POP_WAIT after the RAM read; every request answers once.
// Remove-all and find walk the stored entries through the single read port;
// a find that hits stops at the first matching entry.
// busy stays high from accept until the response strobe; a new request may be
// accepted in the cycle the response is shown.
// Synchronous reset empties the deque; memory contents are not cleared.
// The response cannot be stalled.
module bounded_deque_with_search
   import bdq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);

   mem_ctl_type   mem_ctl;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [31:0]   wr_data;
   logic [31:0]   rd_data;

   bdq_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .mem_ctl  (mem_ctl),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   bdq_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .mem_ctl(mem_ctl),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

endmodule

### test/deque_checker.sv
`timescale 1ns / 100ps

module deque_checker
   import bdq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      outstanding
);

   logic signed [31:0] ring [DEPTH];
   int                 head;
   int                 fill;
   rsp_type            answers_due [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
      head        = 0;
      fill        = 0;
   end

   function automatic rsp_type deque_apply(req_type r);
      rsp_type            o;
      int                 kept;
      logic signed [31:0] e;
      o = '0;
      case (r.action)
         ACT_PUSH_FRONT: begin
            if (fill >= DEPTH) begin
               o.status = STATUS_FULL;
            end else begin
               head = (head + DEPTH - 1) % DEPTH;
               ring[head] = r.value;
               fill++;
            end
         end
         ACT_PUSH_BACK: begin
            if (fill >= DEPTH) begin
               o.status = STATUS_FULL;
            end else begin
               ring[(head + fill) % DEPTH] = r.value;
               fill++;
            end
         end
         ACT_POP_FRONT: begin
            if (fill == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               o.popped_value = ring[head];
               head = (head + 1) % DEPTH;
               fill--;
            end
         end
         ACT_POP_BACK: begin
            if (fill == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               o.popped_value = ring[(head + fill - 1) % DEPTH];
               fill--;
            end
         end
         ACT_REMOVE_ALL: begin
            kept = 0;
            for (int i = 0; i < fill; i++) begin
               e = ring[(head + i) % DEPTH];
               if (e != r.value) begin
                  ring[(head + kept) % DEPTH] = e;
                  kept++;
               end
            end
            o.removed_count = 7'(fill - kept);
            fill = kept;
         end
         ACT_FIND: begin
            o.status = STATUS_NOT_FOUND;
            for (int i = 0; i < fill && !o.found; i++) begin
               if (ring[(head + i) % DEPTH] == r.value) begin
                  o.found    = 1'b1;
                  o.position = 6'(i);
                  o.status   = STATUS_OK;
               end
            end
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < 40) begin
         $display("ERROR at %0t: %s got %0h want %0h", $realtime, what, got, want);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         head = 0;
         fill = 0;
         answers_due.delete();
      end else begin
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               report_mismatch("response with no transaction pending", 32'(rsp_data), '0);
            end else begin
               want = answers_due.pop_front();
               if (rsp_data.popped_value !== want.popped_value)
                  report_mismatch("popped_value", rsp_data.popped_value, want.popped_value);
               if (rsp_data.removed_count !== want.removed_count)
                  report_mismatch("removed_count", 32'(rsp_data.removed_count),
                                  32'(want.removed_count));
               if (rsp_data.found !== want.found)
                  report_mismatch("found", 32'(rsp_data.found), 32'(want.found));
               if (rsp_data.position !== want.position)
                  report_mismatch("position", 32'(rsp_data.position), 32'(want.position));
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            end
         end
         if (start && !busy) begin
            answers_due.push_back(deque_apply(req_data));
         end
      end
      outstanding <= answers_due.size();
   end

endmodule

### test/bounded_deque_with_search_test.sv
`timescale 1ns / 100ps

module bounded_deque_with_search_test;
   import bdq_pkg::*;

   localparam int         DEPTH       = 64;
   localparam int         RANDOM_OPS  = 1550;
   localparam logic [2:0] ACT_SPARE_A = 3'd6;
   localparam logic [2:0] ACT_SPARE_B = 3'd7;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      mismatches;
   int      outstanding;

   logic signed [31:0] pool [8];
   int                 pool_size;
   int                 burst_left;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   bounded_deque_with_search #(.DEPTH(DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   deque_checker #(.DEPTH(DEPTH)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   task automatic issue(logic [2:0] act, logic signed [31:0] val);
      start    <= 1'b1;
      req_data <= '{action: act, value: val};
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic signed [31:0] any_value();
      case ($urandom_range(0, 4))
         0: return VAL_MIN;
         1: return VAL_MAX;
         2: return 32'($urandom_range(0, 15)) - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [31:0] pool_value();
      if ($urandom_range(0, 5) == 0) return $urandom;
      return pool[$urandom_range(0, pool_size - 1)];
   endfunction

   function automatic logic [2:0] pick_action(int kind);
      int r;
      r = $urandom_range(0, 99);
      case (kind)
         0: begin
            if (r < 40) return ACT_PUSH_FRONT;
            if (r < 80) return ACT_PUSH_BACK;
            if (r < 85) return ACT_POP_FRONT;
            if (r < 90) return ACT_POP_BACK;
            if (r < 95) return ACT_FIND;
            return ACT_REMOVE_ALL;
         end
         1: begin
            if (r < 10) return ACT_PUSH_FRONT;
            if (r < 20) return ACT_PUSH_BACK;
            if (r < 55) return ACT_POP_FRONT;
            if (r < 90) return ACT_POP_BACK;
            if (r < 95) return ACT_FIND;
            return ACT_REMOVE_ALL;
         end
         2: begin
            if (r < 15) return ACT_PUSH_FRONT;
            if (r < 30) return ACT_PUSH_BACK;
            if (r < 45) return ACT_POP_FRONT;
            if (r < 60) return ACT_POP_BACK;
            if (r < 77) return ACT_FIND;
            if (r < 94) return ACT_REMOVE_ALL;
            if (r < 97) return ACT_SPARE_A;
            return ACT_SPARE_B;
         end
         default: begin
            if (r < 25) return ACT_PUSH_FRONT;
            if (r < 50) return ACT_PUSH_BACK;
            if (r < 55) return ACT_POP_FRONT;
            if (r < 60) return ACT_POP_BACK;
            if (r < 82) return ACT_FIND;
            return ACT_REMOVE_ALL;
         end
      endcase
   endfunction

   initial begin
      int done;
      int kind;
      int phase_len;
      int gap_mode;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue(ACT_POP_FRONT, VAL_MAX);
      issue(ACT_POP_BACK, VAL_MIN);
      issue(ACT_FIND, 32'sd0);
      issue(ACT_REMOVE_ALL, 32'sd0);
      issue(ACT_SPARE_A, $urandom);
      issue(ACT_SPARE_B, $urandom);
      issue(ACT_PUSH_BACK, VAL_MAX);
      issue(ACT_PUSH_FRONT, VAL_MIN);
      issue(ACT_PUSH_BACK, -32'sd1);
      issue(ACT_PUSH_FRONT, 32'sd0);
      issue(ACT_PUSH_BACK, VAL_MAX);
      issue(ACT_FIND, VAL_MAX);
      issue(ACT_FIND, VAL_MIN);
      issue(ACT_FIND, 32'sd12345);
      issue(ACT_REMOVE_ALL, VAL_MAX);
      issue(ACT_REMOVE_ALL, 32'sd777);
      issue(ACT_FIND, -32'sd1);
      issue(ACT_POP_BACK, $urandom);
      issue(ACT_POP_FRONT, $urandom);
      issue(ACT_POP_FRONT, $urandom);
      issue(ACT_POP_BACK, $urandom);
      issue(ACT_POP_FRONT, $urandom);
      drain();

      done = 0;
      burst_left = 0;
      while (done < RANDOM_OPS) begin
         kind      = $urandom_range(0, 4);
         phase_len = $urandom_range(20, 120);
         gap_mode  = $urandom_range(0, 2);
         pool_size = (kind == 4) ? 1 : $urandom_range(1, 8);
         for (int k = 0; k < pool_size; k++) pool[k] = any_value();
         for (int n = 0; n < phase_len && done < RANDOM_OPS; n++) begin
            if (gap_mode != 0 && burst_left == 0) begin
               hold_off($urandom_range(1, gap_mode == 1 ? 3 : 12));
               burst_left = $urandom_range(1, 16);
            end
            if (burst_left > 0) burst_left--;
            issue(pick_action(kind == 4 ? 0 : kind), pool_value());
            done++;
         end
         if ($urandom_range(0, 3) == 0) drain();
      end

      drain();
      repeat (80) @(posedge clock);
      if (mismatches == 0) begin
         $display("bounded_deque_with_search: match");
      end else begin
         $display("bounded_deque_with_search: mismatch");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("bounded_deque_with_search: mismatch");
      $finish;
   end

endmodule

### filelist.f
design/bdq_pkg.sv
design/bdq_ram.sv
design/bdq_ctrl.sv
design/bounded_deque_with_search.sv
test/deque_checker.sv
test/bounded_deque_with_search_test.sv
